@@ hw/rtl/twc_pkg.sv @@
// twc_pkg: shared types and constants of the text console writer
// screen cell layout, operation codes, character codes and reset values
// no dependencies
package twc_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// fixed field widths of the item and result ports
	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int X_W     = 7;
	localparam int Y_W     = 5;
	localparam int POS_W   = 11;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUT   = 2'd0,
		FN_WRITE = 2'd1,
		FN_CLEAR = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	// one screen cell: attribute in the high byte, character in the low byte
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [CHAR_W-1:0]  chr;
	} cell_t;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

	localparam int TAB_STEP = 8;

	// attribute after reset, also the color of the power-on screen
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

endpackage

@@ hw/rtl/twc_screen_ram.sv @@
// twc_screen_ram: screen cell memory, one write and one read port
// read data registered; depends on twc_pkg
module twc_screen_ram #(
	parameter int DEPTH  = twc_pkg::COLUMNS_DEF * twc_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  twc_pkg::cell_t      wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output twc_pkg::cell_t      rdata
);
	import twc_pkg::*;

	cell_t mem_q [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/text_console_writer.sv @@
// text_console_writer: text screen with cursor, put char / write / clear / read
// top level; depends on twc_pkg and twc_screen_ram
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    func char_code cell_x cell_y cell_color
//   out      source     out_valid / out_ready  cursor_pos read_char read_color
//   cfg      sink       cfg_we                 cfg_wdata (text_color)
//
// put char, write cell and read cell latch the item on accept, then make their screen ram
// access in the execute state; read cell adds the read state for the registered ram read
// clear sweeps every cell, one ram write per cell
// a scroll adds a sweep of every cell: a pipelined copy through the single ram port pair
// after reset a clearing pass blanks the screen; no item is taken until it is done
// a stalled result holds in the output register; the next item is taken as it leaves
module text_console_writer #(
	parameter int COLUMNS = twc_pkg::COLUMNS_DEF,
	parameter int ROWS    = twc_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item input
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [twc_pkg::FUNC_W-1:0]   func,
	input  logic [twc_pkg::CHAR_W-1:0]   char_code,
	input  logic [twc_pkg::X_W-1:0]      cell_x,
	input  logic [twc_pkg::Y_W-1:0]      cell_y,
	input  logic [twc_pkg::COLOR_W-1:0]  cell_color,
	// result output
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [twc_pkg::POS_W-1:0]    cursor_pos,
	output logic [twc_pkg::CHAR_W-1:0]   read_char,
	output logic [twc_pkg::COLOR_W-1:0]  read_color,
	// text color register
	input  logic                         cfg_we,
	input  logic [twc_pkg::COLOR_W-1:0]  cfg_wdata
);
	import twc_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int LIN_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

	localparam logic [COL_W:0]      COLS_X    = (COL_W+1)'(COLUMNS);
	localparam logic [ROW_W:0]      ROWS_X    = (ROW_W+1)'(ROWS);
	localparam logic [COL_W-1:0]    LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [LIN_W-1:0]    COLS_L    = LIN_W'(COLUMNS);
	localparam logic [ADDR_W-1:0]   COLS_A    = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0]   LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0]   COPY_END  = ADDR_W'((ROWS - 1) * COLUMNS);

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_READ   = 6'b001000,
		ST_CLEAR  = 6'b010000,
		ST_SCROLL = 6'b100000
	} state_t;

	state_t state_q;

	// latched item
	func_t               func_q;
	logic [CHAR_W-1:0]   char_q;
	logic [X_W-1:0]      x_q;
	logic [Y_W-1:0]      y_q;
	logic [COLOR_W-1:0]  color_q;

	logic [COLOR_W-1:0]  text_color_q;
	logic [COL_W-1:0]    cursor_col_q;
	logic [ROW_W-1:0]    cursor_row_q;
	logic [ADDR_W-1:0]   sweep_q;

	// scroll copy write stage, in the cycle after the read it waits for
	logic                wr_vld_s1;
	logic                wr_copy_s1;
	logic [ADDR_W-1:0]   wr_addr_s1;

	// result register
	logic                out_valid_q;
	logic [POS_W-1:0]    cursor_pos_q;
	logic [CHAR_W-1:0]   read_char_q;
	logic [COLOR_W-1:0]  read_color_q;

	// ram ports
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	cell_t               mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	cell_t               mem_rdata;

	logic                in_take;
	logic                cell_in_range;
	logic                scroll_copy;
	logic [LIN_W-1:0]    cur_lin;
	logic [LIN_W-1:0]    nxt_lin;
	logic [LIN_W-1:0]    cell_lin;
	cell_t               blank_cell;

	// put char: next cursor before wrap resolution is folded in below
	logic [COL_W:0]      pc_col;
	logic [ROW_W:0]      pc_row;
	logic                pc_we;
	logic                pc_bs;
	logic                pc_scroll;

	// an item is only taken when the result register is free by the time it completes
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_take  = in_valid && in_ready;

	assign blank_cell    = '{color: text_color_q, chr: CH_SPACE};
	assign cell_in_range = ({1'b0, x_q} < (X_W+1)'(COLUMNS)) &&
	                       ({2'b00, y_q} < (Y_W+2)'(ROWS));
	assign scroll_copy   = sweep_q < COPY_END;

	assign cur_lin  = LIN_W'(cursor_row_q) * COLS_L + LIN_W'(cursor_col_q);
	assign nxt_lin  = LIN_W'(pc_row) * COLS_L + LIN_W'(pc_col);
	assign cell_lin = LIN_W'(y_q) * COLS_L + LIN_W'(x_q);

	// terminal rules for put char
	always_comb begin
		pc_col = {1'b0, cursor_col_q};
		pc_row = {1'b0, cursor_row_q};
		pc_we  = 1'b0;
		pc_bs  = 1'b0;
		case (char_q)
			CH_BS: begin
				pc_we = 1'b1;
				pc_bs = 1'b1;
				if (cursor_col_q != '0) begin
					pc_col = {1'b0, cursor_col_q} - 1'b1;
				end else if (cursor_row_q != '0) begin
					// back over the row start onto the last column above
					pc_row = {1'b0, cursor_row_q} - 1'b1;
					pc_col = {1'b0, LAST_COL};
				end
			end
			CH_TAB: pc_col = {1'b0, cursor_col_q} + (COL_W+1)'(TAB_STEP);
			CH_CR:  pc_col = '0;
			CH_LF: begin
				pc_row = {1'b0, cursor_row_q} + 1'b1;
				pc_col = '0;
			end
			default: begin
				if (char_q >= CH_SPACE && char_q <= CH_DEL) begin
					pc_we  = 1'b1;
					pc_col = {1'b0, cursor_col_q} + 1'b1;
				end
			end
		endcase
		// past the last column: wrap to the next row
		if (pc_col >= COLS_X) begin
			pc_col = '0;
			pc_row = pc_row + 1'b1;
		end
		pc_scroll = (pc_row == ROWS_X);
	end

	// ram access steering; the scroll write stage owns the write port while it runs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = blank_cell;
		mem_re    = 1'b0;
		mem_raddr = cell_lin[ADDR_W-1:0];
		if (wr_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = wr_copy_s1 ? mem_rdata : blank_cell;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					mem_we    = 1'b1;
					mem_wdata = '{color: RESET_COLOR, chr: CH_SPACE};
				end
				ST_CLEAR: mem_we = 1'b1;
				ST_EXEC: begin
					unique case (func_q)
						FN_PUT: begin
							mem_we    = pc_we;
							// backspace blanks the cell it lands on
							mem_waddr = pc_bs ? nxt_lin[ADDR_W-1:0] : cur_lin[ADDR_W-1:0];
							mem_wdata = pc_bs ? blank_cell :
							            '{color: text_color_q, chr: char_q};
						end
						FN_WRITE: begin
							mem_we    = cell_in_range;
							mem_waddr = cell_lin[ADDR_W-1:0];
							mem_wdata = '{color: color_q, chr: char_q};
						end
						FN_CLEAR, FN_READ: ;
						default: ;
					endcase
				end
				ST_IDLE, ST_READ, ST_SCROLL: ;
				default: ;
			endcase
		end
		// scroll reads run one row ahead of the writes, so they never meet
		if (state_q == ST_SCROLL) begin
			mem_re    = scroll_copy;
			mem_raddr = sweep_q + COLS_A;
		end else if (state_q == ST_EXEC && func_q == FN_READ) begin
			mem_re = cell_in_range;
		end
	end

	twc_screen_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer, cursor and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_q      <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			text_color_q <= RESET_COLOR;
			wr_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			wr_vld_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					sweep_q <= '0;
					unique case (func_q)
						FN_PUT: begin
							if (pc_scroll) begin
								cursor_row_q <= LAST_ROW;
								cursor_col_q <= '0;
								state_q      <= ST_SCROLL;
							end else begin
								cursor_row_q <= pc_row[ROW_W-1:0];
								cursor_col_q <= pc_col[COL_W-1:0];
								out_valid_q  <= 1'b1;
								state_q      <= ST_IDLE;
							end
						end
						FN_WRITE: begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
						FN_CLEAR: begin
							cursor_row_q <= '0;
							cursor_col_q <= '0;
							state_q      <= ST_CLEAR;
						end
						FN_READ: begin
							if (cell_in_range) begin
								state_q <= ST_READ;
							end else begin
								out_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_CLEAR, ST_SCROLL: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_CELL) begin
						// the last scroll write drains from the write stage next cycle
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item latch, scroll write stage and result payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q  <= func_t'(func);
			char_q  <= char_code;
			x_q     <= cell_x;
			y_q     <= cell_y;
			color_q <= cell_color;
		end
		wr_addr_s1 <= sweep_q;
		wr_copy_s1 <= scroll_copy;
		unique case (state_q)
			ST_EXEC: begin
				// put char reports its moved cursor, the others the current one; clear and scroll report from their sweep
				cursor_pos_q <= (func_q == FN_PUT) ? nxt_lin[POS_W-1:0] : cur_lin[POS_W-1:0];
				read_char_q  <= '0;
				read_color_q <= '0;
			end
			ST_READ: begin
				cursor_pos_q <= cur_lin[POS_W-1:0];
				read_char_q  <= mem_rdata.chr;
				read_color_q <= mem_rdata.color;
			end
			ST_CLEAR, ST_SCROLL: begin
				cursor_pos_q <= cur_lin[POS_W-1:0];
				read_char_q  <= '0;
				read_color_q <= '0;
			end
			ST_INIT, ST_IDLE: ;
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign read_char  = read_char_q;
	assign read_color = read_color_q;

	// cursor stays on the screen
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cursor_col_q} < COLS_X) && ({1'b0, cursor_row_q} < ROWS_X))
		else $error("cursor left the screen");

	// the scroll write stage never collides with an item's own ram write
	a_no_write_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> (state_q != ST_EXEC) && (state_q != ST_CLEAR))
		else $error("scroll write overlaps another write");

	// write cell finishes in its execute cycle
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && func_q == FN_WRITE) |=> out_valid_q && (state_q == ST_IDLE))
		else $error("write cell did not complete");

	// no item is taken while a previous result is still pending in the pipeline
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_EXEC) && !out_valid_q)
		else $error("item taken with result register busy");

endmodule

@@ test/text_console_monitor.sv @@
`timescale 1ns / 1ps
// text_console_monitor: watches the item, result and color channels of the text console
// writer, keeps its own screen and cursor, and checks each result field by field
// depends on twc_pkg
module text_console_monitor #(
	parameter int COLUMNS = twc_pkg::COLUMNS_DEF,
	parameter int ROWS    = twc_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [twc_pkg::FUNC_W-1:0]   func,
	input  logic [twc_pkg::CHAR_W-1:0]   char_code,
	input  logic [twc_pkg::X_W-1:0]      cell_x,
	input  logic [twc_pkg::Y_W-1:0]      cell_y,
	input  logic [twc_pkg::COLOR_W-1:0]  cell_color,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [twc_pkg::POS_W-1:0]    cursor_pos,
	input  logic [twc_pkg::CHAR_W-1:0]   read_char,
	input  logic [twc_pkg::COLOR_W-1:0]  read_color,
	input  logic                         cfg_we,
	input  logic [twc_pkg::COLOR_W-1:0]  cfg_wdata,
	output int                           fail_count,
	output int                           pending
);
	import twc_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [CHAR_W-1:0]  rd_char;
		logic [COLOR_W-1:0] rd_color;
	} report_t;

	cell_t              screen_mem [CELLS];
	int unsigned        cur_col;
	int unsigned        cur_row;
	logic [COLOR_W-1:0] ink;
	report_t            expected_reports [$];

	function automatic void blank_cells(int unsigned from, int unsigned upto);
		int unsigned i;
		for (i = from; i < upto; i++)
			screen_mem[i] = cell_t'({ink, CH_SPACE});
	endfunction

	// terminal rules for one byte
	function automatic void type_char(logic [CHAR_W-1:0] ch);
		int unsigned i;
		if (ch == CH_BS) begin
			if (cur_col > 0)
				cur_col--;
			else if (cur_row > 0) begin
				cur_row--;
				cur_col = COLUMNS - 1;
			end
			screen_mem[cur_row * COLUMNS + cur_col] = cell_t'({ink, CH_SPACE});
		end else if (ch == CH_TAB) begin
			cur_col += TAB_STEP;
		end else if (ch == CH_CR) begin
			cur_col = 0;
		end else if (ch == CH_LF) begin
			cur_row++;
			cur_col = 0;
		end else if (ch >= CH_SPACE && ch <= CH_DEL) begin
			screen_mem[cur_row * COLUMNS + cur_col] = cell_t'({ink, ch});
			cur_col++;
		end else begin
			return;
		end
		if (cur_col >= COLUMNS) begin
			cur_row++;
			cur_col = 0;
		end
		// scroll up one row
		if (cur_row >= ROWS) begin
			for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
				screen_mem[i] = screen_mem[i + COLUMNS];
			blank_cells((ROWS - 1) * COLUMNS, CELLS);
			cur_row = ROWS - 1;
		end
	endfunction

	function automatic report_t apply_item(func_t fn, logic [CHAR_W-1:0] ch,
			logic [X_W-1:0] x, logic [Y_W-1:0] y, logic [COLOR_W-1:0] color);
		report_t r;
		bit      on_screen;
		r = '0;
		on_screen = (x < COLUMNS) && (y < ROWS);
		case (fn)
			FN_PUT: begin
				type_char(ch);
			end
			FN_WRITE: begin
				if (on_screen)
					screen_mem[y * COLUMNS + x] = cell_t'({color, ch});
			end
			FN_CLEAR: begin
				blank_cells(0, CELLS);
				cur_col = 0;
				cur_row = 0;
			end
			FN_READ: begin
				if (on_screen) begin
					r.rd_char  = screen_mem[y * COLUMNS + x].chr;
					r.rd_color = screen_mem[y * COLUMNS + x].color;
				end
			end
		endcase
		r.pos = POS_W'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		if (!arst_n) begin
			ink = RESET_COLOR;
			blank_cells(0, CELLS);
			cur_col = 0;
			cur_row = 0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("result with no item outstanding, cursor_pos %0d", cursor_pos);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (cursor_pos !== want.pos) begin
						$error("cursor_pos: expected %0d, actual %0d", want.pos, cursor_pos);
						fail_count++;
					end
					if (read_char !== want.rd_char) begin
						$error("read_char: expected %h, actual %h", want.rd_char, read_char);
						fail_count++;
					end
					if (read_color !== want.rd_color) begin
						$error("read_color: expected %h, actual %h", want.rd_color, read_color);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				ink = cfg_wdata;
			if (in_valid && in_ready)
				expected_reports.push_back(apply_item(func_t'(func), char_code, cell_x,
					cell_y, cell_color));
			pending = expected_reports.size();
		end
	end

endmodule

@@ test/text_console_writer_test.sv @@
`timescale 1ns / 1ps
// text_console_writer_test: drives directed and random items into the text console writer
// with random gaps and output stalls; the monitor predicts and checks each result
// depends on twc_pkg, text_console_writer and text_console_monitor
module text_console_writer_test;
	import twc_pkg::*;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func       = '0;
	logic [CHAR_W-1:0]    char_code  = '0;
	logic [X_W-1:0]       cell_x     = '0;
	logic [Y_W-1:0]       cell_y     = '0;
	logic [COLOR_W-1:0]   cell_color = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [POS_W-1:0]     cursor_pos;
	logic [CHAR_W-1:0]    read_char;
	logic [COLOR_W-1:0]   read_color;
	logic                 cfg_we     = 1'b0;
	logic [COLOR_W-1:0]   cfg_wdata  = '0;
	int                   fail_count;
	int                   pending;

	// when set, neither side idles: back-to-back items and an always ready sink
	bit                   no_idle    = 1'b0;
	int                   stall_left = 0;

	text_console_writer u_top (.*);

	text_console_monitor u_monitor (.*);

	always #5 clk = ~clk;

	// result sink: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		if (no_idle) begin
			out_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin : pick_stall
			int r;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				out_ready <= 1'b1;
				stall_left <= $urandom_range(0, 6);
			end else if (r < 95) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(10, 40);
			end
		end
	end

	// idle cycles before the next item: mostly none, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// present one item and hold it until accepted; valid stays high when the next
	// item follows with no gap, so it is lowered only before an idle stretch
	task automatic send_item(func_t fn, logic [CHAR_W-1:0] ch, logic [X_W-1:0] x,
			logic [Y_W-1:0] y, logic [COLOR_W-1:0] color);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= fn;
		char_code  <= ch;
		cell_x     <= x;
		cell_y     <= y;
		cell_color <= color;
		do @(posedge clk); while (!in_ready);
	endtask

	// put char with junk in the unused fields
	task automatic put(logic [CHAR_W-1:0] ch);
		send_item(FN_PUT, ch, X_W'($urandom), Y_W'($urandom), COLOR_W'($urandom));
	endtask

	// stop sending and wait for every outstanding result; the count is sampled on the
	// falling edge so it is settled, and control returns on a rising edge
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// text color write, only issued while nothing is in flight
	task automatic set_color(logic [COLOR_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one random item; lf_pct steers between long lines and many short lines
	task automatic random_item(int lf_pct, int clr_pct);
		int               r;
		logic [CHAR_W-1:0] ch;
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
		x = X_W'($urandom_range(0, COLUMNS_DEF - 1));
		y = ($urandom_range(0, 3) == 0) ? Y_W'(ROWS_DEF - 1) :
		    Y_W'($urandom_range(0, ROWS_DEF - 1));
		// some coordinates off the screen, up to the full field width
		if ($urandom_range(0, 9) == 0) begin
			x = X_W'($urandom_range(0, 127));
			y = Y_W'($urandom_range(0, 31));
		end
		r = $urandom_range(0, 99);
		if (r < clr_pct) begin
			send_item(FN_CLEAR, CHAR_W'($urandom), X_W'($urandom), Y_W'($urandom),
				COLOR_W'($urandom));
		end else if (r < clr_pct + 10) begin
			send_item(FN_WRITE, CHAR_W'($urandom), x, y, COLOR_W'($urandom));
		end else if (r < clr_pct + 28) begin
			send_item(FN_READ, CHAR_W'($urandom), x, y, COLOR_W'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < lf_pct)
				ch = CH_LF;
			else if (r < lf_pct + 8)
				ch = CH_TAB;
			else if (r < lf_pct + 12)
				ch = CH_CR;
			else if (r < lf_pct + 20)
				ch = CH_BS;
			else if (r < lf_pct + 28)
				ch = CHAR_W'($urandom);  // any byte; high ones and unhandled control ones are dropped
			else
				ch = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
			put(ch);
		end
	endtask

	initial begin
		int phase;
		int n;
		int lf_pct;
		int clr_pct;
		logic [COLOR_W-1:0] color;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset color
		// power-on screen is blank at both corners
		send_item(FN_READ, 8'hFF, 7'd0, 5'd0, 8'hFF);
		send_item(FN_READ, 8'h00, 7'd79, 5'd24, 8'h00);
		// printable range ends, then dropped bytes
		put(CH_SPACE);
		put(CH_DEL);
		put(8'h00);
		put(8'h1F);
		put(8'h80);
		put(8'hFF);
		// carriage return, then backspace at the origin stays home
		put(CH_CR);
		put(CH_BS);
		// backspace at column 0 goes to the end of the previous row
		put(CH_LF);
		put(CH_BS);
		// direct writes at the extremes, one off the screen
		send_item(FN_WRITE, 8'hFF, 7'd79, 5'd24, 8'hFF);
		send_item(FN_WRITE, 8'h00, 7'd0, 5'd0, 8'h00);
		send_item(FN_WRITE, 8'hAA, 7'd127, 5'd31, 8'h55);
		send_item(FN_READ, 8'h00, 7'd79, 5'd24, 8'h00);
		send_item(FN_READ, 8'h00, 7'd127, 5'd31, 8'h00);
		send_item(FN_READ, 8'h00, 7'd80, 5'd0, 8'h00);
		// clear, then a tab run off the end of the row wraps to the next one
		send_item(FN_CLEAR, 8'h55, 7'h2A, 5'h15, 8'hAA);
		send_item(FN_READ, 8'h00, 7'd0, 5'd0, 8'h00);
		for (n = 0; n < 10; n++)
			put(CH_TAB);

		// random phases; each starts from an idle block with a new text color
		for (phase = 0; phase < 8; phase++) begin
			wait_drained();
			lf_pct  = (phase % 2 == 1) ? 40 : phase;  // alternate many lines / long lines
			clr_pct = (phase == 4 || phase == 7) ? 2 : 0;
			color   = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);
			no_idle = (phase == 2 || phase == 5);
			set_color(color);
			for (n = 0; n < 54; n++)
				random_item(lf_pct, clr_pct);
		end

		no_idle = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
